// ----- design/drvl_pkg.sv -----
// ----------------------------------------------------------------------------
// Data run VCN to LCN lookup: shared package
// Status codes, field widths and the records passed to the end-of-run unit.
// ----------------------------------------------------------------------------
`default_nettype none

package drvl_pkg;

  localparam int unsigned VCN_W = 48;
  localparam int unsigned ACC_W = 64;

  localparam logic [1:0] ST_MAPPED = 2'd0;
  localparam logic [1:0] ST_SPARSE = 2'd1;
  localparam logic [1:0] ST_BOUNDS = 2'd2;
  localparam logic [1:0] ST_END    = 2'd3;

  typedef struct packed {
    logic [ACC_W-1:0] count_accum;
    logic [ACC_W-1:0] offset_accum;
    logic [3:0]       offset_bytes;
    logic [VCN_W-1:0] running_cluster;
    logic [VCN_W-1:0] run_base;
    logic [VCN_W-1:0] held_query;
  } run_end_in_t;

  typedef struct packed {
    logic             hit;
    logic             sparse;
    logic [VCN_W-1:0] physical_cluster;
    logic [VCN_W-1:0] clusters_left;
    logic [VCN_W-1:0] running_cluster;
    logic [VCN_W-1:0] run_base;
  } run_end_out_t;

endpackage

`default_nettype wire

// ----- design/drvl_run_end.sv -----
// ----------------------------------------------------------------------------
// Data run VCN to LCN lookup: end-of-run arithmetic
// Sign-extends the run's cluster delta, advances the absolute cluster and
// tests whether the held query falls inside the run just decoded.
// ----------------------------------------------------------------------------
`default_nettype none

module drvl_run_end (
  input  wire drvl_pkg::run_end_in_t run_in,
  output drvl_pkg::run_end_out_t     run_out
);

  logic [5:0]                 sign_pos;
  logic                       sign_bit;
  logic                       extend;
  logic [drvl_pkg::VCN_W-1:0] delta;
  logic [drvl_pkg::VCN_W-1:0] into;
  logic                       query_ge_base;

  // Only the low 48 bits of the delta reach any output; for fields of up to six bytes a
  // zero delta is exactly a zero offset field, since sign extension only ever adds ones.
  always_comb begin
    sign_pos = {run_in.offset_bytes[2:0] - 3'd1, 3'd7};
    sign_bit = run_in.offset_accum[sign_pos];
    extend   = sign_bit && (run_in.offset_bytes != 4'd0) && !run_in.offset_bytes[3];
    for (int k = 0; k < 6; k++) begin
      if (extend && (4'(k) >= run_in.offset_bytes)) begin
        delta[8*k +: 8] = 8'hFF;
      end else begin
        delta[8*k +: 8] = run_in.offset_accum[8*k +: 8];
      end
    end
  end

  assign query_ge_base = run_in.held_query >= run_in.run_base;
  assign into          = run_in.held_query - run_in.run_base;

  assign run_out.hit     = query_ge_base && ({16'd0, into} < run_in.count_accum);
  assign run_out.sparse  = run_in.offset_accum == '0;
  assign run_out.running_cluster  = run_in.running_cluster + delta;
  assign run_out.physical_cluster = run_in.running_cluster + delta + into;
  assign run_out.clusters_left    = run_in.count_accum[drvl_pkg::VCN_W-1:0] - into;
  assign run_out.run_base = run_in.run_base + run_in.count_accum[drvl_pkg::VCN_W-1:0];

endmodule

`default_nettype wire

// ----- design/data_run_vcn_to_lcn_lookup_top.sv -----
// ----------------------------------------------------------------------------
// Data run VCN to LCN lookup: top level
// Decodes a mapping pairs list one byte per word and reports the physical
// cluster and run remainder for a queried virtual cluster.
// ----------------------------------------------------------------------------
// An accepted byte's result passes the input register, then the result register.
// Throughput: one byte per cycle; the only pause is while a result is stalled.
// Reset: synchronous; the decoder comes up idle and ignores bytes until a
// word with first_byte set, and both bound registers read as zero.
`default_nettype none

module data_run_vcn_to_lcn_lookup_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  run_byte,
  input  wire logic        first_byte,
  input  wire logic [47:0] query_vcn,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [47:0]      physical_cluster,
  output logic [47:0]      clusters_left,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_COUNT,
    PH_OFFSET
  } phase_t;

  // Configuration registers.
  logic [47:0] low_vcn;
  logic [47:0] high_vcn;

  // Input register.
  logic        ib_valid;
  logic [7:0]  ib_byte;
  logic        ib_first;
  logic [47:0] ib_query;

  // Decoder state.
  phase_t      phase, phase_next;
  logic        finished, finished_next;
  logic [3:0]  count_bytes, count_bytes_next;
  logic [3:0]  offset_bytes, offset_bytes_next;
  logic [3:0]  byte_position, byte_position_next;
  logic [63:0] count_accum, count_accum_next;
  logic [63:0] offset_accum, offset_accum_next;
  logic [47:0] running_cluster, running_cluster_next;
  logic [47:0] run_base, run_base_next;
  logic [47:0] held_query, held_query_next;

  logic        blocked;
  logic        step;
  logic        emit;
  logic [1:0]  emit_status;
  logic [47:0] emit_cluster;
  logic [47:0] emit_left;
  logic        cfg_write;
  logic [3:0]  bp_inc;

  drvl_pkg::run_end_in_t  run_in;
  drvl_pkg::run_end_out_t run_out;

  function automatic logic [63:0] put_byte(input logic [63:0] acc, input logic [3:0] pos,
                                           input logic [7:0] b);
    logic [63:0] res;
    res = acc;
    for (int k = 0; k < 8; k++) begin
      if (!pos[3] && (pos[2:0] == 3'(k))) begin
        res[8*k +: 8] = acc[8*k +: 8] | b;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- APB port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = paddr[3] ? {16'd0, high_vcn} : {16'd0, low_vcn};

  always_ff @(posedge clk) begin
    if (rst) begin
      low_vcn  <= '0;
      high_vcn <= '0;
    end else if (cfg_write) begin
      if (paddr[3]) begin
        high_vcn <= pwdata[47:0];
      end else begin
        low_vcn <= pwdata[47:0];
      end
    end
  end

  // ------------------------------------------------------------ handshaking
  assign blocked  = out_valid && out_stall;
  assign in_stall = ib_valid && blocked;
  assign step     = ib_valid && !blocked;

  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (!in_stall) begin
      ib_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ib_byte  <= run_byte;
      ib_first <= first_byte;
      ib_query <= query_vcn;
    end
  end

  // ------------------------------------------------------------ decode step
  assign run_in.count_accum     = count_accum_next;
  assign run_in.offset_accum    = offset_accum_next;
  assign run_in.offset_bytes    = offset_bytes;
  assign run_in.running_cluster = running_cluster;
  assign run_in.run_base        = run_base;
  assign run_in.held_query      = held_query;

  drvl_run_end u_run_end (
    .run_in  (run_in),
    .run_out (run_out)
  );

  assign bp_inc = byte_position + 4'd1;

  always_comb begin
    phase_next           = phase;
    finished_next        = finished;
    count_bytes_next     = count_bytes;
    offset_bytes_next    = offset_bytes;
    byte_position_next   = byte_position;
    count_accum_next     = count_accum;
    offset_accum_next    = offset_accum;
    running_cluster_next = running_cluster;
    run_base_next        = run_base;
    held_query_next      = held_query;
    emit                 = 1'b0;
    emit_status          = drvl_pkg::ST_MAPPED;
    emit_cluster         = '0;
    emit_left            = '0;

    if (step) begin
      if (ib_first) begin
        held_query_next      = ib_query;
        running_cluster_next = '0;
        run_base_next        = low_vcn;
        phase_next           = PH_HEADER;
        finished_next        = 1'b0;
      end
      if (ib_first && ((ib_query < low_vcn) || (ib_query > high_vcn))) begin
        emit          = 1'b1;
        emit_status   = drvl_pkg::ST_BOUNDS;
        finished_next = 1'b1;
      end else if (ib_first || !finished) begin
        case (ib_first ? PH_HEADER : phase)
          PH_HEADER: begin
            if (ib_byte == 8'd0) begin
              emit          = 1'b1;
              emit_status   = drvl_pkg::ST_END;
              finished_next = 1'b1;
            end else begin
              count_bytes_next   = ib_byte[3:0];
              offset_bytes_next  = ib_byte[7:4];
              byte_position_next = '0;
              count_accum_next   = '0;
              offset_accum_next  = '0;
              phase_next         = (ib_byte[3:0] != 4'd0) ? PH_COUNT : PH_OFFSET;
            end
          end
          PH_COUNT: begin
            count_accum_next   = put_byte(count_accum, byte_position, ib_byte);
            byte_position_next = bp_inc;
            if (bp_inc >= count_bytes) begin
              byte_position_next = '0;
              phase_next         = PH_OFFSET;
            end
          end
          PH_OFFSET: begin
            offset_accum_next  = put_byte(offset_accum, byte_position, ib_byte);
            byte_position_next = bp_inc;
            if (bp_inc >= offset_bytes) begin
              byte_position_next = '0;
            end
          end
          default: begin
            phase_next = PH_HEADER;
          end
        endcase

        // The run is complete on its last count byte when it has no offset
        // field, or on its last offset byte.
        if (!ib_first && (((phase == PH_COUNT) && (bp_inc >= count_bytes) &&
                           (offset_bytes == 4'd0)) ||
                          ((phase == PH_OFFSET) && (bp_inc >= offset_bytes)))) begin
          phase_next           = PH_HEADER;
          running_cluster_next = run_out.running_cluster;
          if (run_out.hit) begin
            emit          = 1'b1;
            finished_next = 1'b1;
            emit_left     = run_out.clusters_left;
            if (run_out.sparse) begin
              emit_status = drvl_pkg::ST_SPARSE;
            end else begin
              emit_status  = drvl_pkg::ST_MAPPED;
              emit_cluster = run_out.physical_cluster;
            end
          end else begin
            run_base_next = run_out.run_base;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      finished      <= 1'b1;
      count_bytes   <= '0;
      offset_bytes  <= '0;
      byte_position <= '0;
    end else begin
      phase         <= phase_next;
      finished      <= finished_next;
      count_bytes   <= count_bytes_next;
      offset_bytes  <= offset_bytes_next;
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    count_accum     <= count_accum_next;
    offset_accum    <= offset_accum_next;
    running_cluster <= running_cluster_next;
    run_base        <= run_base_next;
    held_query      <= held_query_next;
  end

  // --------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status           <= emit_status;
      physical_cluster <= emit_cluster;
      clusters_left    <= emit_left;
    end
  end

  // -------------------------------------------------------------- assertions
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (ib_valid && blocked) |=> ib_valid)
    else $error("Input word lost while the result register was stalled.");

  a_no_cluster: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == drvl_pkg::ST_SPARSE || status == drvl_pkg::ST_BOUNDS ||
                   status == drvl_pkg::ST_END)) |-> (physical_cluster == '0))
    else $error("Cluster reported for a sparse or unmatched lookup.");

  a_no_left: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == drvl_pkg::ST_BOUNDS || status == drvl_pkg::ST_END))
      |-> (clusters_left == '0))
    else $error("Run remainder reported for an unmatched lookup.");

  a_emit_idles: assert property (@(posedge clk) disable iff (rst)
    emit |=> (finished && out_valid))
    else $error("Decoder kept running after giving its result.");

  a_count_phase: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_COUNT) |-> (count_bytes != 4'd0))
    else $error("Count field entered with an empty count length.");

endmodule

`default_nettype wire
